### design/sjfq_pkg.sv
// shared types and constants for the shortest-job-first ready queue
// depends on nothing; every other file of the block imports it
package sjfq_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int TIME_BITS     = 16;
    localparam int BURST_BITS    = 16;
    localparam int SLOT_BITS     = $clog2(MAX_PROCESSES);
    localparam int CNT_BITS      = $clog2(MAX_PROCESSES + 1);

    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [BURST_BITS-1:0] burst_t;

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_TICK      = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_SET_BURST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_REMOVE,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t    opcode;
        time_t  entry_time;
        burst_t burst_time;
        slot_t  slot;
        time_t  now_time;
    } cmd_item_t;

    typedef struct packed {
        status_t status;
        slot_t   head_slot;
        logic    head_valid;
        slot_t   shortest_slot;
        logic    shortest_valid;
        logic    work_left;
        count_t  queue_count;
        count_t  table_count;
    } rsp_item_t;

    // feeds of the shared compare unit during the summary walk
    typedef struct packed {
        logic   clear;
        logic   q_valid;
        slot_t  q_slot;
        burst_t q_burst;
        logic   w_valid;
        burst_t w_burst;
    } scan_ctrl_t;

    typedef struct packed {
        slot_t head_slot;
        slot_t best_slot;
        logic  work_left;
    } scan_res_t;

endpackage

### design/sjfq_cmd_if.sv
// command channel: valid/ready handshake carrying one operation
// depends on sjfq_pkg
interface sjfq_cmd_if;
    import sjfq_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### design/sjfq_rsp_if.sv
// result channel: valid/ready handshake carrying one queue summary
// depends on sjfq_pkg
interface sjfq_rsp_if;
    import sjfq_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### design/sjfq_scan_unit.sv
// shared compare unit: tracks head, shortest burst and nonzero burst over a walk
// depends on sjfq_pkg
module sjfq_scan_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sjfq_pkg::scan_ctrl_t ctrl,
    output sjfq_pkg::scan_res_t  res
);
    import sjfq_pkg::*;

    logic   have_reg;
    logic   work_reg;
    burst_t best_burst_reg;
    slot_t  best_slot_reg;
    slot_t  head_slot_reg;
    logic   take;

    // strict less keeps the earliest queued slot on a tie
    assign take = ctrl.q_valid && (!have_reg || (ctrl.q_burst < best_burst_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            work_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            have_reg <= 1'b0;
            work_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.q_valid)
                have_reg <= 1'b1;
            if (ctrl.w_valid && (ctrl.w_burst != '0))
                work_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctrl.clear && take)
        begin
            best_burst_reg <= ctrl.q_burst;
            best_slot_reg  <= ctrl.q_slot;
        end
        // first queued entry seen is the front of the queue
        if (!ctrl.clear && ctrl.q_valid && !have_reg)
            head_slot_reg <= ctrl.q_slot;
    end

    assign res.head_slot = head_slot_reg;
    assign res.best_slot = best_slot_reg;
    assign res.work_left = work_reg;

endmodule

### design/sjf_ready_queue_top.sv
// top level of the shortest-job-first ready queue: sequencer, table and queue memories
// depends on sjfq_pkg, sjfq_cmd_if, sjfq_rsp_if and sjfq_scan_unit
//
//  channel | role   | transaction
//  --------+--------+-------------------------------------------------
//  cmd     | sink   | one operation: add, tick, remove or set burst
//  rsp     | source | one summary of the queue after that operation
//
// an operation takes its own walk (tick: over the table; remove of a queued slot: over the
// queue; others: none) then a summary walk over the longer of queue and table, one entry per
// cycle through the memory read ports; the done state then loads the result register and the
// idle state accepts the next transaction. cmd.ready is high only in the idle state; a result
// waiting on rsp holds the sequencer in its last state. reset empties queue and table.
module sjf_ready_queue_top
(
    input  logic        clk,
    input  logic        rst_n,
    sjfq_cmd_if.sink    cmd,
    sjfq_rsp_if.source  rsp
);
    import sjfq_pkg::*;

    // memories
    time_t  arr_mem   [MAX_PROCESSES];
    burst_t burst_mem [MAX_PROCESSES];
    slot_t  order_mem [MAX_PROCESSES];

    time_t  arr_rd_reg;
    burst_t bqa_rd_reg;
    burst_t bqb_rd_reg;
    slot_t  order_rd_reg;

    logic   arr_we;
    slot_t  arr_waddr;
    time_t  arr_wdata;
    logic   burst_we;
    slot_t  burst_waddr;
    burst_t burst_wdata;
    logic   order_we;
    slot_t  order_waddr;
    slot_t  order_wdata;
    slot_t  rd_addr;

    // control state
    state_t  state_reg, state_next;
    count_t  idx_reg, idx_next;
    logic    p1_valid_reg, p1_valid_next;
    slot_t   p1_idx_reg, p1_idx_next;
    logic    found_reg, found_next;
    logic    s1_q_reg, s1_q_next;
    logic    s1_w_reg, s1_w_next;
    logic    s2_q_reg, s2_q_next;
    slot_t   s2_slot_reg, s2_slot_next;
    count_t  qlen_reg, qlen_next;
    count_t  tlen_reg, tlen_next;
    logic [MAX_PROCESSES-1:0] flags_reg, flags_next;
    logic    out_valid_reg, out_valid_next;

    // payload state
    slot_t     slot_reg;
    time_t     now_reg;
    status_t   status_reg, status_next;
    rsp_item_t out_reg;
    logic      out_load;

    scan_ctrl_t scan_ctrl;
    scan_res_t  scan_res;

    logic accept;
    logic in_range;
    logic present;
    logic issue_t, issue_q, issue_w;
    logic walk_done;
    logic scan_done;

    assign accept   = cmd.valid && cmd.ready;
    assign in_range = CNT_BITS'(cmd.item.slot) < tlen_reg;
    assign present  = in_range && flags_reg[cmd.item.slot];

    assign issue_t   = idx_reg < tlen_reg;
    assign issue_q   = idx_reg < qlen_reg;
    assign issue_w   = idx_reg < tlen_reg;
    assign walk_done = !((state_reg == S_TICK) ? issue_t : issue_q) && !p1_valid_reg;
    assign scan_done = !issue_q && !issue_w && !s1_q_reg && !s1_w_reg && !s2_q_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.item.opcode)
                        OP_TICK:   state_next = S_TICK;
                        OP_REMOVE: state_next = present ? S_REMOVE : S_SCAN;
                        default:   state_next = S_SCAN;
                    endcase
                end
            end
            S_TICK, S_REMOVE:
            begin
                if (walk_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer and datapath control
    always_comb
    begin
        idx_next       = idx_reg;
        p1_valid_next  = 1'b0;
        p1_idx_next    = p1_idx_reg;
        found_next     = found_reg;
        s1_q_next      = 1'b0;
        s1_w_next      = 1'b0;
        s2_q_next      = 1'b0;
        s2_slot_next   = order_rd_reg;
        qlen_next      = qlen_reg;
        tlen_next      = tlen_reg;
        flags_next     = flags_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        arr_we      = 1'b0;
        arr_waddr   = tlen_reg[SLOT_BITS-1:0];
        arr_wdata   = cmd.item.entry_time;
        burst_we    = 1'b0;
        burst_waddr = tlen_reg[SLOT_BITS-1:0];
        burst_wdata = cmd.item.burst_time;
        order_we    = 1'b0;
        order_waddr = qlen_reg[SLOT_BITS-1:0];
        order_wdata = p1_idx_reg;

        scan_ctrl.clear   = 1'b0;
        scan_ctrl.q_valid = 1'b0;
        scan_ctrl.q_slot  = s2_slot_reg;
        scan_ctrl.q_burst = bqa_rd_reg;
        scan_ctrl.w_valid = 1'b0;
        scan_ctrl.w_burst = bqb_rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    found_next      = 1'b0;
                    scan_ctrl.clear = 1'b1;
                    status_next     = ST_OK;
                    case (cmd.item.opcode)
                        OP_ADD:
                        begin
                            if (tlen_reg == CNT_BITS'(MAX_PROCESSES))
                                status_next = ST_FULL;
                            else
                            begin
                                arr_we   = 1'b1;
                                burst_we = 1'b1;
                                flags_next[tlen_reg[SLOT_BITS-1:0]] = 1'b0;
                                tlen_next = tlen_reg + CNT_BITS'(1);
                            end
                        end
                        OP_TICK: status_next = ST_OK;
                        OP_REMOVE:
                        begin
                            if (!present)
                                status_next = ST_ABSENT;
                        end
                        OP_SET_BURST:
                        begin
                            if (!in_range)
                                status_next = ST_ABSENT;
                            else
                            begin
                                burst_we    = 1'b1;
                                burst_waddr = cmd.item.slot;
                            end
                        end
                        default: status_next = ST_OK;
                    endcase
                end
            end
            S_TICK:
            begin
                if (issue_t)
                begin
                    idx_next      = idx_reg + CNT_BITS'(1);
                    p1_valid_next = 1'b1;
                    p1_idx_next   = idx_reg[SLOT_BITS-1:0];
                end
                if (p1_valid_reg && (arr_rd_reg == now_reg) && !flags_reg[p1_idx_reg]
                    && (qlen_reg < CNT_BITS'(MAX_PROCESSES)))
                begin
                    order_we               = 1'b1;
                    flags_next[p1_idx_reg] = 1'b1;
                    qlen_next              = qlen_reg + CNT_BITS'(1);
                end
                if (walk_done)
                    idx_next = '0;
            end
            S_REMOVE:
            begin
                if (issue_q)
                begin
                    idx_next      = idx_reg + CNT_BITS'(1);
                    p1_valid_next = 1'b1;
                    p1_idx_next   = idx_reg[SLOT_BITS-1:0];
                end
                if (p1_valid_reg)
                begin
                    // entries behind the removed one move up a place
                    if (found_reg)
                    begin
                        order_we    = 1'b1;
                        order_waddr = p1_idx_reg - SLOT_BITS'(1);
                        order_wdata = order_rd_reg;
                    end
                    if (order_rd_reg == slot_reg)
                        found_next = 1'b1;
                end
                if (walk_done)
                begin
                    idx_next             = '0;
                    found_next           = 1'b0;
                    qlen_next            = qlen_reg - CNT_BITS'(1);
                    flags_next[slot_reg] = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (issue_q || issue_w)
                    idx_next = idx_reg + CNT_BITS'(1);
                s1_q_next         = issue_q;
                s1_w_next         = issue_w;
                s2_q_next         = s1_q_reg;
                scan_ctrl.w_valid = s1_w_reg;
                scan_ctrl.q_valid = s2_q_reg;
            end
            S_DONE:
            begin
                if (out_load)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign rd_addr = idx_reg[SLOT_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (arr_we)
            arr_mem[arr_waddr] <= arr_wdata;
        if (burst_we)
            burst_mem[burst_waddr] <= burst_wdata;
        if (order_we)
            order_mem[order_waddr] <= order_wdata;
        arr_rd_reg   <= arr_mem[rd_addr];
        order_rd_reg <= order_mem[rd_addr];
        bqa_rd_reg   <= burst_mem[order_rd_reg];
        bqb_rd_reg   <= burst_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            p1_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            s1_q_reg      <= 1'b0;
            s1_w_reg      <= 1'b0;
            s2_q_reg      <= 1'b0;
            qlen_reg      <= '0;
            tlen_reg      <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            p1_valid_reg  <= p1_valid_next;
            found_reg     <= found_next;
            s1_q_reg      <= s1_q_next;
            s1_w_reg      <= s1_w_next;
            s2_q_reg      <= s2_q_next;
            qlen_reg      <= qlen_next;
            tlen_reg      <= tlen_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg  <= p1_idx_next;
        s2_slot_reg <= s2_slot_next;
        status_reg  <= status_next;
        if (accept)
        begin
            slot_reg <= cmd.item.slot;
            now_reg  <= cmd.item.now_time;
        end
        if (out_load)
        begin
            out_reg.status         <= status_reg;
            out_reg.head_slot      <= (qlen_reg != '0) ? scan_res.head_slot : '0;
            out_reg.head_valid     <= (qlen_reg != '0);
            out_reg.shortest_slot  <= (qlen_reg != '0) ? scan_res.best_slot : '0;
            out_reg.shortest_valid <= (qlen_reg != '0);
            out_reg.work_left      <= scan_res.work_left;
            out_reg.queue_count    <= qlen_reg;
            out_reg.table_count    <= tlen_reg;
        end
    end

    sjfq_scan_unit u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .res   (scan_res)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

endmodule
